/* sv/dtkr_pkg.sv */
// Shared types and constants of the double-tap key resolver.
// Used by the controller, the datapath and the top level; no dependencies.
package dtkr_pkg;

    // defaults and fixed limits
    localparam int ENTRIES_DEF = 8;
    localparam logic [15:0] TERM_RESET = 16'd200;
    localparam int MAX_OUT = 8;
    localparam int EMIT_W = 4;

    // beat widths
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 24;
    localparam int ACT_W = 2;

    // action selector on s_tuser
    localparam logic [ACT_W-1:0] ACT_KEY  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SCAN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD = 2'd2;

    // result kind on m_tuser
    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_TAP    = 1'b1;

    // apb register index
    localparam logic REG_TAP_TERM = 1'b0;

    // one table entry as held in the entry ram
    typedef struct packed {
        logic [15:0] trig_code;
        logic [15:0] single_code;
        logic [15:0] double_code;
        logic        armed;
        logic [1:0]  tap_cnt;
        logic [15:0] first_ms;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller to datapath
    typedef struct packed {
        logic start;      // capture item, read entry 0
        logic advance;    // move to next entry
        logic key_done;   // key search finished, latch match
        logic wr_entry;   // write back the evaluated entry
        logic load_wr;    // write a table entry from the input beat
        logic pend_take;  // hold a new tap code as pending
        logic push_mid;   // send pending code, more follow
        logic push_key;   // send key answer
        logic push_last;  // send pending code as final result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic due;
        logic emits;
        logic at_end;
        logic emit_full;
        logic pend_valid;
        logic out_free;
        logic pressed;
    } stat_t;

endpackage

/* sv/dtkr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/dtkr_ctrl.sv */
// Sequencer of the double-tap key resolver: input handshake and entry walk.
// Depends on dtkr_pkg for the command and status structs.
module dtkr_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dtkr_pkg::ACT_W-1:0]    s_tuser,
    input  dtkr_pkg::stat_t               st,
    output dtkr_pkg::cmd_t                cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_KEY     = 3'd1;
    localparam logic [2:0] S_KEY_OUT = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_FLUSH   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       s_fire;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire = s_tvalid && s_tready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        dtkr_pkg::ACT_KEY: begin
                            cmd.start = 1'b1;
                            state_next = S_KEY;
                        end
                        dtkr_pkg::ACT_SCAN: begin
                            cmd.start = 1'b1;
                            state_next = S_SCAN;
                        end
                        dtkr_pkg::ACT_LOAD: begin
                            cmd.load_wr = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_KEY: begin
                // first match ends the search
                if (st.hit || st.at_end) begin
                    cmd.key_done = 1'b1;
                    cmd.wr_entry = st.hit && st.pressed;
                    state_next = S_KEY_OUT;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            S_KEY_OUT: begin
                if (st.out_free) begin
                    cmd.push_key = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                // a new code pushes the pending one out, so wait for room
                if (!(st.emits && st.pend_valid && !st.out_free)) begin
                    cmd.wr_entry = st.due;
                    cmd.pend_take = st.emits;
                    cmd.push_mid = st.emits && st.pend_valid;
                    if (st.at_end || (st.emits && st.emit_full)) begin
                        state_next = S_FLUSH;
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!st.pend_valid) begin
                    state_next = S_IDLE;
                end else if (st.out_free) begin
                    cmd.push_last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // assertions
    a_one_push: assert property (@(posedge aclk) disable iff (!aresetn)
        !((cmd.push_key && cmd.push_mid) || (cmd.push_key && cmd.push_last)
          || (cmd.push_mid && cmd.push_last)))
        else $error("two results pushed in one cycle");
    a_start_then_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (state_reg == S_KEY || state_reg == S_SCAN))
        else $error("item start did not begin an entry walk");
    a_flush_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH && !st.pend_valid) |=> state_reg == S_IDLE)
        else $error("flush with nothing pending did not return to idle");

endmodule

/* sv/dtkr_dpath.sv */
// Datapath of the double-tap key resolver: item register, entry ram walk,
// pending tap code and output register. Depends on dtkr_pkg and dtkr_ram.
module dtkr_dpath #(
    parameter int ENTRIES = dtkr_pkg::ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [dtkr_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [dtkr_pkg::ACT_W-1:0]      s_tuser,
    input  logic [15:0]                     tap_term,
    input  dtkr_pkg::cmd_t                  cmd,
    output dtkr_pkg::stat_t                 st,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dtkr_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PAD_W = dtkr_pkg::M_DATA_W - 17;

    // input beat fields
    logic [15:0] in_key;
    logic        in_pressed;
    logic [15:0] in_now;
    logic [2:0]  in_index;
    logic [15:0] in_single;
    logic [15:0] in_double;

    assign in_key     = s_tdata[15:0];
    assign in_pressed = s_tdata[16];
    assign in_now     = s_tdata[32:17];
    assign in_index   = s_tdata[35:33];
    assign in_single  = s_tdata[51:36];
    assign in_double  = s_tdata[67:52];

    // captured item
    logic [15:0] key_reg;
    logic        pressed_reg;
    logic [15:0] now_reg;
    logic        is_scan_reg;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg     <= in_key;
            pressed_reg <= in_pressed;
            now_reg     <= in_now;
            is_scan_reg <= (s_tuser == dtkr_pkg::ACT_SCAN);
        end
    end

    // walk index and read address
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;

    always_comb begin
        idx_next = idx_reg;
        if (cmd.start) begin
            idx_next = '0;
        end else if (cmd.advance) begin
            idx_next = idx_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    // entry ram with valid bits, an unwritten entry reads as zero
    logic [ENTRIES-1:0]     valid_reg;
    logic                   valid_q_reg;
    logic                   ld_ok;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    dtkr_pkg::entry_t       ram_wdata;
    dtkr_pkg::entry_t       ram_rdata;
    dtkr_pkg::entry_t       cur;
    dtkr_pkg::entry_t       wb_entry;
    dtkr_pkg::entry_t       ld_entry;

    assign ld_ok = ({29'd0, in_index} < 32'(ENTRIES));
    assign ram_we = (cmd.load_wr && ld_ok) || cmd.wr_entry;
    assign ram_waddr = cmd.load_wr ? AW'(in_index) : idx_reg;

    always_comb begin
        ld_entry = '0;
        ld_entry.trig_code = in_key;
        ld_entry.single_code = in_single;
        ld_entry.double_code = in_double;
    end

    assign ram_wdata = cmd.load_wr ? ld_entry : wb_entry;

    dtkr_ram #(
        .WIDTH (dtkr_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            valid_q_reg <= 1'b0;
        end else begin
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            valid_q_reg <= valid_reg[idx_next];
        end
    end

    assign cur = valid_q_reg ? ram_rdata : '0;

    // entry evaluation
    logic [15:0] elapsed;
    logic        hit;
    logic        due;
    logic        emits;
    logic [15:0] emit_code;

    assign hit = (cur.trig_code == key_reg);
    assign elapsed = now_reg - cur.first_ms;
    assign due = cur.armed && (elapsed > tap_term);
    assign emits = due && (cur.tap_cnt != 2'd0);
    assign emit_code = (cur.tap_cnt == 2'd1) ? cur.single_code : cur.double_code;

    // updated entry: arm or count a press on a key walk, disarm on a scan
    always_comb begin
        wb_entry = cur;
        if (is_scan_reg) begin
            wb_entry.armed = 1'b0;
            wb_entry.tap_cnt = 2'd0;
        end else if (!cur.armed) begin
            wb_entry.armed = 1'b1;
            wb_entry.tap_cnt = 2'd1;
            wb_entry.first_ms = now_reg;
        end else if (cur.tap_cnt < 2'd2) begin
            wb_entry.tap_cnt = cur.tap_cnt + 2'd1;
        end
    end

    // key match, pending tap code and emit count
    logic                         hit_reg;
    logic                         pend_valid_reg;
    logic [15:0]                  pend_code_reg;
    logic [dtkr_pkg::EMIT_W-1:0]  emit_cnt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.key_done) begin
            hit_reg <= hit;
        end
        if (cmd.pend_take) begin
            pend_code_reg <= emit_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            emit_cnt_reg <= '0;
        end else begin
            if (cmd.start) begin
                pend_valid_reg <= 1'b0;
                emit_cnt_reg <= '0;
            end else if (cmd.pend_take) begin
                pend_valid_reg <= 1'b1;
                emit_cnt_reg <= emit_cnt_reg + dtkr_pkg::EMIT_W'(1);
            end else if (cmd.push_last) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    logic        m_valid_reg;
    logic        m_kind_reg;
    logic [15:0] m_code_reg;
    logic        m_handled_reg;
    logic        m_last_reg;
    logic        out_free;
    logic        push;

    assign out_free = !m_valid_reg || m_tready;
    assign push = cmd.push_key || cmd.push_mid || cmd.push_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_key) begin
            m_kind_reg <= dtkr_pkg::KIND_ANSWER;
            m_code_reg <= 16'd0;
            m_handled_reg <= hit_reg;
            m_last_reg <= 1'b1;
        end else if (cmd.push_mid || cmd.push_last) begin
            m_kind_reg <= dtkr_pkg::KIND_TAP;
            m_code_reg <= pend_code_reg;
            m_handled_reg <= 1'b0;
            m_last_reg <= cmd.push_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {{PAD_W{1'b0}}, m_handled_reg, m_code_reg};
    assign m_tuser = m_kind_reg;
    assign m_tlast = m_last_reg;

    // status
    always_comb begin
        st = '0;
        st.hit = hit;
        st.due = due;
        st.emits = emits;
        st.at_end = (idx_reg == AW'(ENTRIES - 1));
        st.emit_full = (emit_cnt_reg == dtkr_pkg::EMIT_W'(dtkr_pkg::MAX_OUT - 1));
        st.pend_valid = pend_valid_reg;
        st.out_free = out_free;
        st.pressed = pressed_reg;
    end

    // assertions
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("result pushed into a full output register");
    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_cnt_reg <= dtkr_pkg::EMIT_W'(dtkr_pkg::MAX_OUT))
        else $error("more tap codes than allowed for one scan");
    a_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_wr && cmd.wr_entry))
        else $error("load and write-back in the same cycle");

endmodule

/* sv/double_tap_key_resolver_core.sv */
// Top level of the double-tap key resolver: apb tap-term register and the
// controller and datapath. Depends on dtkr_pkg, dtkr_ctrl, dtkr_dpath, dtkr_ram.
//
//  channel  dir  beat contents
//  s_       in   tuser action; tdata key, pressed, now_ms, index, single, double
//  m_       out  tuser kind; tdata out_code, handled; tlast last
//  apb      in   register 0 at address 0: tap_term_ms (16 bits, reset 200)
//
// A load is written into its table entry when it is accepted. A key event is
// accepted, visits the entries up to the first match, and hands over its answer.
// A scan is accepted, visits every entry (ENTRIES in all, fewer when the eighth
// code ends the walk) and closes by handing over its final code, if any; the
// pace is one entry per cycle of the entry ram's read port while no full output
// register holds the walk. A full output register holds a key answer and a final
// code in place, and holds the walk whenever a second tap code is ready. Reset
// clears all entries through per-entry valid bits at once; no sweep.
module double_tap_key_resolver_core #(
    parameter int ENTRIES = dtkr_pkg::ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input item channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key_code[15:0], pressed[16], now_ms[32:17], entry_index[35:33],
    // single_code[51:36], double_code[67:52], zero fill[71:68]
    input  logic [dtkr_pkg::S_DATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [dtkr_pkg::ACT_W-1:0]      s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_code[15:0], handled[16], zero fill[23:17]
    output logic [dtkr_pkg::M_DATA_W-1:0]   m_tdata,
    // kind[0]
    output logic                            m_tuser,
    output logic                            m_tlast,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    // tap term register
    logic [15:0] term_reg;
    logic        reg_sel;

    assign pready = 1'b1;
    assign reg_sel = (paddr[2] == dtkr_pkg::REG_TAP_TERM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg <= dtkr_pkg::TERM_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            term_reg <= pwdata[15:0];
        end
    end

    assign prdata = reg_sel ? {16'd0, term_reg} : 32'd0;

    dtkr_pkg::cmd_t  cmd;
    dtkr_pkg::stat_t st;

    dtkr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .st       (st),
        .cmd      (cmd)
    );

    dtkr_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .tap_term (term_reg),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench of the double-tap key resolver core.
// Drives key, scan and load beats, predicts every result beat in step and
// checks it; depends on dtkr_pkg and double_tap_key_resolver_core only.
module tb_top;

    localparam int ENTRIES = dtkr_pkg::ENTRIES_DEF;
    localparam int DRAIN_CYCLES = 4 * ENTRIES + 24;
    localparam int LIMIT_CYCLES = 800000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 348;
    localparam int PHASES = 4;
    localparam logic [dtkr_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_TAP_TERM = {dtkr_pkg::REG_TAP_TERM, 2'b00};
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    // one input beat as its fields
    typedef struct packed {
        logic [dtkr_pkg::ACT_W-1:0] action;
        logic [15:0]      key_code;
        logic             pressed;
        logic [15:0]      now_ms;
        logic [2:0]       entry_idx;
        logic [15:0]      sgl_code;
        logic [15:0]      dbl_code;
    } tap_item_t;

    // one result beat as its fields
    typedef struct packed {
        logic        kind;
        logic [15:0] code;
        logic        handled;
        logic        last;
    } tap_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [dtkr_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic [dtkr_pkg::ACT_W-1:0]      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [dtkr_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [2:0]                      paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    // predicted table contents and tap term
    logic [15:0] trig_tab [ENTRIES];
    logic [15:0] sgl_tab [ENTRIES];
    logic [15:0] dbl_tab [ENTRIES];
    logic        armed_tab [ENTRIES];
    logic [1:0]  taps_tab [ENTRIES];
    logic [15:0] first_tab [ENTRIES];
    logic [15:0] term_ms;

    tap_result_t due_results [$];

    logic no_gaps = 1'b0;
    logic rx_hold = 1'b0;
    int   rx_wait = 0;
    int   err_count = 0;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   codes_seen = 0;
    int   answers_seen = 0;

    double_tap_key_resolver_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always #4 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("[%0d] mismatch: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 17);
    endfunction

    // tap resolution: table search on keys, term check on scans, table writes on loads
    function automatic void resolve_taps(input tap_item_t it);
        tap_result_t r;
        tap_result_t burst [dtkr_pkg::MAX_OUT];
        logic [15:0] elapsed;
        int n;
        n = 0;
        r = '0;
        case (it.action)
            dtkr_pkg::ACT_KEY: begin
                r.kind = dtkr_pkg::KIND_ANSWER;
                r.last = 1'b1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (trig_tab[i] == it.key_code) begin
                        r.handled = 1'b1;
                        if (it.pressed) begin
                            if (!armed_tab[i]) begin
                                armed_tab[i] = 1'b1;
                                taps_tab[i] = 2'd1;
                                first_tab[i] = it.now_ms;
                            end else if (taps_tab[i] < 2'd2) begin
                                taps_tab[i] = taps_tab[i] + 2'd1;
                            end
                        end
                        break;
                    end
                end
                due_results.push_back(r);
            end
            dtkr_pkg::ACT_SCAN: begin
                for (int i = 0; i < ENTRIES && n < dtkr_pkg::MAX_OUT; i++) begin
                    elapsed = it.now_ms - first_tab[i];
                    if (armed_tab[i] && elapsed > term_ms) begin
                        if (taps_tab[i] != 2'd0) begin
                            burst[n] = '0;
                            burst[n].kind = dtkr_pkg::KIND_TAP;
                            burst[n].code = (taps_tab[i] == 2'd1) ? sgl_tab[i] : dbl_tab[i];
                            n++;
                        end
                        armed_tab[i] = 1'b0;
                        taps_tab[i] = 2'd0;
                    end
                end
                for (int k = 0; k < n; k++) begin
                    burst[k].last = (k == n - 1);
                    due_results.push_back(burst[k]);
                end
            end
            dtkr_pkg::ACT_LOAD: begin
                if (int'(it.entry_idx) < ENTRIES) begin
                    trig_tab[it.entry_idx] = it.key_code;
                    sgl_tab[it.entry_idx] = it.sgl_code;
                    dbl_tab[it.entry_idx] = it.dbl_code;
                    armed_tab[it.entry_idx] = 1'b0;
                    taps_tab[it.entry_idx] = 2'd0;
                end
            end
            default: ;
        endcase
    endfunction

    // one input beat, predicted at acceptance
    task automatic send_item(input tap_item_t it);
        int gap;
        gap = draw_wait();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= it.action;
        s_tdata  <= {4'h0, it.dbl_code, it.sgl_code, it.entry_idx, it.now_ms,
                     it.pressed, it.key_code};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        resolve_taps(it);
        items_sent++;
    endtask

    // unused fields of each beat carry random values
    task automatic send_key(input logic [15:0] key, input logic pressed,
                            input logic [15:0] now);
        tap_item_t it;
        logic [95:0] fill;
        fill = {$urandom, $urandom, $urandom};
        it = fill[$bits(tap_item_t)-1:0];
        it.action = dtkr_pkg::ACT_KEY;
        it.key_code = key;
        it.pressed = pressed;
        it.now_ms = now;
        send_item(it);
    endtask

    task automatic send_scan(input logic [15:0] now);
        tap_item_t it;
        logic [95:0] fill;
        fill = {$urandom, $urandom, $urandom};
        it = fill[$bits(tap_item_t)-1:0];
        it.action = dtkr_pkg::ACT_SCAN;
        it.now_ms = now;
        send_item(it);
    endtask

    task automatic send_load(input logic [2:0] idx, input logic [15:0] key,
                             input logic [15:0] sgl, input logic [15:0] dbl);
        tap_item_t it;
        logic [95:0] fill;
        fill = {$urandom, $urandom, $urandom};
        it = fill[$bits(tap_item_t)-1:0];
        it.action = dtkr_pkg::ACT_LOAD;
        it.entry_idx = idx;
        it.key_code = key;
        it.sgl_code = sgl;
        it.dbl_code = dbl;
        send_item(it);
    endtask

    // drop valid, wait for every result, then let a scan or load finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_tap_term();
        logic [31:0] rd;
        apb_access(1'b0, ADDR_TAP_TERM, 32'h0, rd);
        if (rd[15:0] !== term_ms)
            report_error($sformatf("tap term read %h want %h", rd[15:0], term_ms));
    endtask

    // upper data bits are junk, only the low 16 land in the register
    task automatic set_tap_term(input logic [15:0] value);
        logic [31:0] rd;
        settle();
        apb_access(1'b1, ADDR_TAP_TERM, {16'($urandom), value}, rd);
        term_ms = value;
        check_tap_term();
    endtask

    // zero trigger on unloaded entries, release, unused action, term boundary
    task automatic test_reset_table();
        tap_item_t junk;
        check_tap_term();
        send_key(16'h0000, 1'b1, 16'h0000);
        send_key(16'hFFFF, 1'b0, 16'hFFFF);
        junk = '1;
        junk.action = ACT_UNUSED;
        send_item(junk);
        send_scan(16'd200);
        send_scan(16'd201);
    endtask

    // double taps with saturation, wrapped timer, shadowed duplicate trigger
    task automatic test_double_tap();
        send_load(3'd7, 16'hFFFF, 16'h0001, 16'hFFFF);
        send_load(3'd1, 16'h1234, 16'hAAAA, 16'h5555);
        send_load(3'd2, 16'h1234, 16'h1111, 16'h2222);
        send_key(16'hFFFF, 1'b1, 16'hFFF0);
        send_key(16'hFFFF, 1'b1, 16'hFFF8);
        send_key(16'hFFFF, 1'b1, 16'hFFFC);
        send_key(16'hFFFF, 1'b0, 16'hFFFE);
        send_key(16'h1234, 1'b1, 16'hFFF0);
        send_scan(16'h00B8);
        send_scan(16'h00B9);
    endtask

    // reload of an armed entry drops its taps
    task automatic test_load_disarms();
        send_key(16'h1234, 1'b1, 16'h0100);
        send_load(3'd1, 16'h1234, 16'hBEEF, 16'hCAFE);
        send_scan(16'h8000);
    endtask

    // term extremes and a write to an unmapped address
    task automatic test_tap_term();
        logic [31:0] rd;
        settle();
        apb_access(1'b1, ADDR_SPARE, 32'hFFFF_FFFF, rd);
        check_tap_term();
        set_tap_term(16'h0000);
        send_key(16'hFFFF, 1'b1, 16'h1000);
        send_scan(16'h1000);
        send_scan(16'h1001);
        set_tap_term(16'hFFFF);
        send_key(16'hFFFF, 1'b1, 16'h0000);
        send_scan(16'hFFFF);
        send_scan(16'h7FFF);
        set_tap_term(dtkr_pkg::TERM_RESET);
    endtask

    // receiver holds off while keys keep coming, then a scan with all entries due
    task automatic test_backpressure();
        logic [15:0] base;
        settle();
        for (int i = 0; i < ENTRIES; i++)
            send_load(3'(i), 16'h0100 + 16'(i), 16'($urandom), 16'($urandom));
        base = 16'($urandom);
        no_gaps <= 1'b1;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++)
            send_key(16'h0100 + 16'($urandom_range(0, ENTRIES - 1)), 1'b1, base);
        for (int i = 0; i < ENTRIES; i++)
            send_key(16'h0100 + 16'(i), 1'b1, base + 16'(i));
        send_scan(base + term_ms + 16'd8);
        no_gaps <= 1'b0;
        // sender waits out every result before carrying on
        settle();
        send_scan(base + term_ms + 16'd9);
    endtask

    // mostly load, tap and scan sequences on a running clock, some noise
    task automatic test_random_traffic();
        logic [15:0] clk_ms;
        logic [95:0] noise_bits;
        int pick;
        int slot;
        clk_ms = 16'($urandom);
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: set_tap_term(16'($urandom_range(0, 120)));
                2: set_tap_term(16'($urandom));
                3: set_tap_term(16'($urandom_range(150, 400)));
                default: set_tap_term(dtkr_pkg::TERM_RESET);
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                if (n % 32 == 0) no_gaps <= ($urandom_range(0, 3) == 0);
                clk_ms += 16'($urandom_range(0, 40));
                if ($urandom_range(0, 19) == 0) clk_ms += 16'($urandom);
                pick = $urandom_range(0, 99);
                slot = $urandom_range(0, ENTRIES - 1);
                if (pick < 8) begin
                    send_load(3'(slot),
                              ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 11)),
                              16'($urandom), 16'($urandom));
                end else if (pick < 55) begin
                    send_key(trig_tab[slot], ($urandom_range(0, 4) != 0), clk_ms);
                end else if (pick < 85) begin
                    send_scan(clk_ms);
                end else begin
                    noise_bits = {$urandom, $urandom, $urandom};
                    send_item(noise_bits[$bits(tap_item_t)-1:0]);
                end
            end
        end
        no_gaps <= 1'b0;
    endtask

    // result receiver with random stalls
    always @(posedge aclk) begin
        int w;
        if (!aresetn || rx_hold) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                w = draw_wait();
                if (w != 0) begin
                    m_tready <= 1'b0;
                    rx_wait  <= w - 1;
                end
            end
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker against the oldest prediction
    always @(posedge aclk) begin
        tap_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tuser == dtkr_pkg::KIND_TAP) codes_seen++;
            else answers_seen++;
            if (due_results.size() == 0) begin
                report_error($sformatf("unexpected result beat kind %b code %h",
                                       m_tuser, m_tdata[15:0]));
            end else begin
                want = due_results.pop_front();
                if (m_tuser !== want.kind)
                    report_error($sformatf("kind %b want %b", m_tuser, want.kind));
                if (m_tdata[15:0] !== want.code)
                    report_error($sformatf("out_code %h want %h", m_tdata[15:0], want.code));
                if (m_tdata[16] !== want.handled)
                    report_error($sformatf("handled %b want %b", m_tdata[16], want.handled));
                if (m_tlast !== want.last)
                    report_error($sformatf("last %b want %b", m_tlast, want.last));
            end
        end
    end

    // test sequence
    initial begin
        term_ms = dtkr_pkg::TERM_RESET;
        for (int i = 0; i < ENTRIES; i++) begin
            trig_tab[i]  = '0;
            sgl_tab[i]   = '0;
            dbl_tab[i]   = '0;
            armed_tab[i] = 1'b0;
            taps_tab[i]  = '0;
            first_tab[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_table();
        test_double_tap();
        test_load_disarms();
        test_tap_term();
        test_backpressure();
        test_random_traffic();

        settle();
        $display("covered %0d input beats: %0d key answers and %0d tap codes checked",
                 items_sent, answers_seen, codes_seen);
        $display("tap terms from 0 to 65535, receiver hold-off of %0d cycles, %0d errors",
                 HOLD_CYCLES, err_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/dtkr_pkg.sv
sv/dtkr_ram.sv
sv/dtkr_ctrl.sv
sv/dtkr_dpath.sv
sv/double_tap_key_resolver_core.sv
tb/sv/tb_top.sv
